FILE: hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the tick scheduler
// Widths, mode codes and the table entry struct.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int IDX_BITS  = $clog2(MAX_PROCS);
    localparam int CNT_BITS  = $clog2(MAX_PROCS + 1);
    localparam int TAG_BITS  = 8;
    localparam int REM_BITS  = 16;
    localparam int PRI_BITS  = 8;
    localparam int OUT_TIME_BITS = 16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    // One table entry as it moves along the chain.
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] arrival;
        logic [REM_BITS-1:0]  remaining;
        logic [PRI_BITS-1:0]  prio;
    } entry_t;

endpackage

FILE: hw/rtl/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell: one storage cell of the rotating process table
// Holds one entry; on a load takes load_entry, else on a shift its neighbor's entry.
// ----------------------------------------------------------------------------
module pts_cell (
    input  logic           clk,
    input  logic           shift,
    input  logic           load,
    input  pts_pkg::entry_t load_entry,
    input  pts_pkg::entry_t prev_entry,
    output pts_pkg::entry_t entry
);
    import pts_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = load_entry;
        end
        else if (shift)
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

FILE: hw/rtl/pts_chain.sv
// ----------------------------------------------------------------------------
// pts_chain: ring of table cells
// Cell 0 is the head; a shift rotates every entry one place toward the head.
// Loads write the cell that holds slot index count at the current rotation.
// ----------------------------------------------------------------------------
module pts_chain (
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        load,
    input  logic [pts_pkg::IDX_BITS-1:0] load_cell,
    input  pts_pkg::entry_t             load_entry,
    input  logic                        head_write,
    input  pts_pkg::entry_t             head_entry,
    output pts_pkg::entry_t             head
);
    import pts_pkg::*;

    entry_t cells [MAX_PROCS];
    entry_t prevs [MAX_PROCS];

    // Head shifts out into the tail; head_write replaces it on the way.
    always_comb
    begin
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            if (i == MAX_PROCS - 1)
            begin
                prevs[i] = head_write ? head_entry : cells[0];
            end
            else
            begin
                prevs[i] = cells[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_PROCS; g++)
    begin : g_cell
        pts_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .load       (load && (load_cell == IDX_BITS'(g))),
            .load_entry (load_entry),
            .prev_entry (prevs[g]),
            .entry      (cells[g])
        );
    end

    assign head = cells[0];
endmodule

FILE: hw/rtl/preemptive_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_tick_scheduler_unit: SRTF / preemptive priority tick scheduler
// Process table kept in a rotating chain of cells, scanned once per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carries mode and load fields. A load transfer appends an
//   entry and returns its slot (load_dropped when the table is full); a tick
//   returns the pick; clear and reserved mode return nothing.
//   out_valid/out_ready holds one result in a register.
// Sequencing:
//   Load and clear: taken in ST_IDLE; loads can follow every cycle while no
//   result is pending or out_ready is high. Tick: one pass (ST_SCAN) rotates
//   the table past the head comparator, ST_UPDATE turns around, and a second
//   pass (ST_FIX) rotates the chosen entry back with its remaining work
//   reduced. No new item is taken until the block is back in ST_IDLE.
// Stall: hold a pending result in the output register; the next item is
//   taken once the result transfers, or in the same cycle it transfers.
// Reset: table empty, time zero, no previous choice, policy 0. Entry contents
//   are not cleared; only entries below the count are ever read.
// Policy is written through cfg_we/cfg_wdata; the user must write it only while idle (not enforced).
// ----------------------------------------------------------------------------
module preemptive_tick_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  proc_tag,
    input  logic [15:0] arrival_time,
    input  logic [15:0] burst_length,
    input  logic [7:0]  prio_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tick_time,
    output logic [7:0]  chosen_tag,
    output logic        is_idle,
    output logic        switched,
    output logic        completed,
    output logic        all_done,
    output logic        load_dropped
);
    import pts_pkg::*;

    typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_UPDATE, ST_FIX } state_t;

    state_t                state_reg;
    logic                  policy_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [IDX_BITS-1:0]   rot_reg;      // logical slot currently at the head
    logic [TIME_BITS-1:0]  time_reg;
    logic [IDX_BITS-1:0]   last_reg;
    logic                  last_valid_reg;
    logic [IDX_BITS:0]     step_reg;
    logic                  found_reg;
    logic [IDX_BITS-1:0]   best_reg;
    logic [REM_BITS-1:0]   best_key_reg;
    logic [TAG_BITS-1:0]   best_tag_reg;
    logic                  busy_rem_reg;  // some entry other than best has work

    logic                  out_valid_reg;
    logic [15:0]           tick_time_reg;
    logic [7:0]            chosen_tag_reg;
    logic                  is_idle_reg;
    logic                  switched_reg;
    logic                  completed_reg;
    logic                  all_done_reg;
    logic                  load_dropped_reg;

    // Whether the chosen entry had one unit of work left, captured during the write-back pass.
    logic                  best_rem_one_reg;
    logic                  is_best_rem_one;

    entry_t                head;
    entry_t                load_entry;
    entry_t                dec_entry;
    logic                  shift;
    logic                  head_write;
    logic                  accept;
    logic                  do_load;
    logic [IDX_BITS-1:0]   slot_idx;
    logic [IDX_BITS-1:0]   load_cell;
    logic                  in_table;
    logic                  ready_now;
    logic [REM_BITS-1:0]   key;
    logic                  better;
    logic                  is_best;
    logic                  fix_last;
    logic                  out_set;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign do_load  = accept && (mode_t'(mode) == MODE_LOAD)
                      && (count_reg < CNT_BITS'(MAX_PROCS));
    assign slot_idx = count_reg[IDX_BITS-1:0];
    // The cell holding logical slot s is s - rot.
    assign load_cell = slot_idx - rot_reg;

    assign load_entry.tag       = proc_tag;
    assign load_entry.arrival   = arrival_time;
    assign load_entry.remaining = burst_length;
    assign load_entry.prio      = prio_level;

    // Head entry checks; its logical index is rot_reg during the scan.
    assign in_table  = {1'b0, rot_reg} < count_reg;
    assign ready_now = in_table && (head.arrival <= time_reg) && (head.remaining != '0);
    assign key       = policy_reg ? REM_BITS'(head.prio) : head.remaining;
    assign better    = ready_now && (!found_reg || key < best_key_reg);

    assign shift      = (state_reg == ST_SCAN) || (state_reg == ST_FIX);
    assign is_best    = (state_reg == ST_FIX) && found_reg && (rot_reg == best_reg);
    assign head_write = is_best;
    always_comb
    begin
        dec_entry           = head;
        dec_entry.remaining = head.remaining - 1'b1;
    end

    // Last cycle of the write-back pass, and any cycle that produces a result.
    assign fix_last = (state_reg == ST_FIX) && (step_reg == (IDX_BITS+1)'(MAX_PROCS - 1));
    assign out_set  = (accept && (mode_t'(mode) == MODE_LOAD)) || fix_last;

    pts_chain u_chain (
        .clk        (clk),
        .shift      (shift),
        .load       (do_load),
        .load_cell  (load_cell),
        .load_entry (load_entry),
        .head_write (head_write),
        .head_entry (dec_entry),
        .head       (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            policy_reg       <= 1'b0;
            count_reg        <= '0;
            rot_reg          <= '0;
            time_reg         <= '0;
            last_reg         <= '0;
            last_valid_reg   <= 1'b0;
            step_reg         <= '0;
            found_reg        <= 1'b0;
            best_reg         <= '0;
            best_key_reg     <= '0;
            best_tag_reg     <= '0;
            busy_rem_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            tick_time_reg    <= '0;
            chosen_tag_reg   <= '0;
            is_idle_reg      <= 1'b0;
            switched_reg     <= 1'b0;
            completed_reg    <= 1'b0;
            all_done_reg     <= 1'b0;
            load_dropped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (mode_t'(mode))
                            MODE_LOAD:
                            begin
                                chosen_tag_reg   <= '0;
                                is_idle_reg      <= 1'b0;
                                switched_reg     <= 1'b0;
                                completed_reg    <= 1'b0;
                                all_done_reg     <= 1'b0;
                                if (do_load)
                                begin
                                    count_reg        <= count_reg + 1'b1;
                                    tick_time_reg    <= 16'(slot_idx);
                                    load_dropped_reg <= 1'b0;
                                end
                                else
                                begin
                                    tick_time_reg    <= '0;
                                    load_dropped_reg <= 1'b1;
                                end
                            end
                            MODE_TICK:
                            begin
                                state_reg    <= ST_SCAN;
                                step_reg     <= '0;
                                found_reg    <= 1'b0;
                                busy_rem_reg <= 1'b0;
                            end
                            MODE_CLEAR:
                            begin
                                count_reg      <= '0;
                                time_reg       <= '0;
                                last_valid_reg <= 1'b0;
                            end
                            MODE_RSVD:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // Examine the head, then rotate it to the tail.
                    if (better)
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= rot_reg;
                        best_key_reg <= key;
                        best_tag_reg <= head.tag;
                    end
                    rot_reg  <= rot_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == (IDX_BITS+1)'(MAX_PROCS - 1))
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    // Rotation is back at zero; start the write-back pass.
                    state_reg <= ST_FIX;
                    step_reg  <= '0;
                end
                ST_FIX:
                begin
                    // Second pass: decrement best and gather done status.
                    if (in_table && !is_best && head.remaining != '0)
                    begin
                        busy_rem_reg <= 1'b1;
                    end
                    rot_reg  <= rot_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                    if (fix_last)
                    begin
                        state_reg     <= ST_IDLE;
                        tick_time_reg <= 16'(time_reg);
                        time_reg      <= time_reg + 1'b1;
                        load_dropped_reg <= 1'b0;
                        if (found_reg)
                        begin
                            chosen_tag_reg <= best_tag_reg;
                            is_idle_reg    <= 1'b0;
                            switched_reg   <= !last_valid_reg || (last_reg != best_reg);
                            completed_reg  <= is_best_rem_one;
                            all_done_reg   <= !busy_rem_reg && !(in_table && !is_best
                                              && head.remaining != '0) && is_best_rem_one;
                            last_reg       <= best_reg;
                            last_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            chosen_tag_reg <= '0;
                            is_idle_reg    <= 1'b1;
                            switched_reg   <= 1'b0;
                            completed_reg  <= 1'b0;
                            all_done_reg   <= !busy_rem_reg && !(in_table
                                              && head.remaining != '0);
                            last_valid_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_rem_one_reg <= 1'b0;
        end
        else if (is_best)
        begin
            best_rem_one_reg <= (head.remaining == REM_BITS'(1));
        end
    end

    assign is_best_rem_one = is_best ? (head.remaining == REM_BITS'(1)) : best_rem_one_reg;

    assign out_valid    = out_valid_reg;
    assign tick_time    = tick_time_reg;
    assign chosen_tag   = chosen_tag_reg;
    assign is_idle      = is_idle_reg;
    assign switched     = switched_reg;
    assign completed    = completed_reg;
    assign all_done     = all_done_reg;
    assign load_dropped = load_dropped_reg;

    // The input side is closed while a tick is being scanned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken during a tick scan");

    // An idle tick never reports a pick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_idle) |-> (chosen_tag == '0 && !switched && !completed))
        else $error("idle tick reports a process");

    // The table never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_PROCS))
        else $error("entry count overflow");
endmodule
